>>> sv/fixed_point_square_root_core_defines.svh
// assertion macros shared by the rtl
`ifndef FIXED_POINT_SQUARE_ROOT_CORE_DEFINES_SVH
`define FIXED_POINT_SQUARE_ROOT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// condition holds at every clock edge out of reset
`define FPS_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("fixed_point_square_root_core check failed");
// condition holds in the cycle after a trigger
`define FPS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("fixed_point_square_root_core check failed");
`else
`define FPS_ASSERT(label, expr)
`define FPS_ASSERT_NEXT(label, pre, post)
`endif

`endif

>>> sv/fpsqrt_pkg.sv
package fpsqrt_pkg;

  localparam int FRAC_BITS = 24;
  localparam int OP_W      = 32;
  localparam int ROOT_W    = 28;
  localparam int M_W       = 24;
  localparam int E_W       = 6;
  localparam int LEAD_W    = 5;
  localparam int D_W       = 26;
  localparam int Q_W       = 25;

  // truncated 2^24 * .41731, .59016, .7071067811
  localparam logic [M_W-1:0] COEF_A = 24'd7001300;
  localparam logic [M_W-1:0] COEF_B = 24'd9901241;
  localparam logic [M_W-1:0] COEF_C = 24'd11863283;

  // per item context carried down the pipe
  typedef struct packed {
    logic                  zero;
    logic [M_W-1:0]        m;
    logic signed [E_W-1:0] e;
    logic [D_W-1:0]        keep;
  } ctx_t;

  // one beat between divider cells
  typedef struct packed {
    logic           valid;
    ctx_t           ctx;
    logic [D_W-1:0] dvsr;
    logic [D_W-1:0] rem;
    logic           lsb;
    logic [Q_W-1:0] quot;
  } div_beat_t;

endpackage

>>> sv/fixed_point_square_root_core.sv
// channel  signals                      width  role
// in       in_valid in_stall operand    32     signed operand, 24 fraction bits
// out      out_valid out_stall root     28     square root, 24 fraction bits
//
// one beat per cycle while out_stall does not hold the pipe, 57 register stages
// most stages are two 25-cell restoring divider chains, one quotient bit per cell
// the whole pipe holds while a result waits under out_stall
// rst clears all valid flags, no clearing pass
module fixed_point_square_root_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fpsqrt_pkg::OP_W-1:0]     operand,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fpsqrt_pkg::ROOT_W-1:0]   root
);
  import fpsqrt_pkg::*;
  `include "fixed_point_square_root_core_defines.svh"

  logic                en;
  logic                n_valid;
  ctx_t                n_ctx;
  logic                p1_valid;
  ctx_t                p1_ctx;
  logic [2*M_W-1:0]    prod1;
  div_beat_t           d1_in;
  div_beat_t           d1;
  div_beat_t           d2_in;
  div_beat_t           d2;
  logic [D_W:0]        s_sum;
  logic [D_W-1:0]      g2;
  logic                p3_valid;
  ctx_t                p3_ctx;
  logic [D_W-1:0]      p3_g;
  logic [M_W+D_W-1:0]  prod3;
  logic                odd;
  logic [D_W-1:0]      g_fin;
  logic signed [E_W-1:0] e_adj;
  logic signed [E_W-1:0] h;
  logic [D_W+15:0]     g_sh;

  // whole pipe moves unless a result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  fpsqrt_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .operand   (operand),
    .out_valid (n_valid),
    .out_ctx   (n_ctx)
  );

  // first guess product b*m
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= n_valid;
    end
    if (en) begin
      p1_ctx <= n_ctx;
      prod1  <= COEF_B * n_ctx.m;
    end
  end

  // first guess a + b*m, load divider one
  always_ff @(posedge clk) begin
    if (rst) begin
      d1_in.valid <= 1'b0;
    end else if (en) begin
      d1_in.valid <= p1_valid;
    end
    if (en) begin
      d1_in.ctx.zero <= p1_ctx.zero;
      d1_in.ctx.m    <= p1_ctx.m;
      d1_in.ctx.e    <= p1_ctx.e;
      d1_in.ctx.keep <= D_W'(COEF_A) + D_W'(prod1[2*M_W-1:FRAC_BITS]);
      d1_in.dvsr     <= D_W'(COEF_A) + D_W'(prod1[2*M_W-1:FRAC_BITS]);
      d1_in.rem      <= D_W'(p1_ctx.m >> 1);
      d1_in.lsb      <= p1_ctx.m[0];
      d1_in.quot     <= '0;
    end
  end

  fpsqrt_div u_div1 (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (d1_in),
    .dout (d1)
  );

  // first newton step s = g + m/g, load divider two
  assign s_sum = (D_W+1)'(d1.ctx.keep) + (D_W+1)'(d1.quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_in.valid <= 1'b0;
    end else if (en) begin
      d2_in.valid <= d1.valid;
    end
    if (en) begin
      d2_in.ctx.zero <= d1.ctx.zero;
      d2_in.ctx.m    <= d1.ctx.m;
      d2_in.ctx.e    <= d1.ctx.e;
      d2_in.ctx.keep <= s_sum[D_W-1:0];
      d2_in.dvsr     <= s_sum[D_W-1:0];
      d2_in.rem      <= D_W'(d1.ctx.m >> 1);
      d2_in.lsb      <= d1.ctx.m[0];
      d2_in.quot     <= '0;
    end
  end

  fpsqrt_div u_div2 (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (d2_in),
    .dout (d2)
  );

  // second newton step s/4 + m/s, then c*g for odd exponent
  assign g2 = (d2.ctx.keep >> 2) + D_W'(d2.quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (en) begin
      p3_valid <= d2.valid;
    end
    if (en) begin
      p3_ctx <= d2.ctx;
      p3_g   <= g2;
      prod3  <= COEF_C * g2;
    end
  end

  // undo half of the normalization
  always_comb begin
    odd   = p3_ctx.e[0];
    g_fin = odd ? prod3[M_W+D_W-1:FRAC_BITS] : p3_g;
    e_adj = p3_ctx.e + E_W'(odd);
    h     = e_adj >>> 1;
    if (h >= 0) begin
      g_sh = (D_W+16)'(g_fin) << h[3:0];
    end else begin
      g_sh = (D_W+16)'(g_fin) >> (-h);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p3_valid;
    end
    if (en) begin
      root <= p3_ctx.zero ? '0 : g_sh[ROOT_W-1:0];
    end
  end

  `FPS_ASSERT(a_div1_rem, !d1.valid || (d1.rem < d1.dvsr))
  `FPS_ASSERT(a_div2_rem, !d2.valid || (d2.rem < d2.dvsr))
  `FPS_ASSERT_NEXT(a_hold_result, out_valid && !en, out_valid && $stable(root))

endmodule

>>> sv/fpsqrt_norm.sv
module fpsqrt_norm (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [fpsqrt_pkg::OP_W-1:0]     operand,
  output logic                            out_valid,
  output fpsqrt_pkg::ctx_t                out_ctx
);
  import fpsqrt_pkg::*;

  logic              a_valid;
  logic              a_zero;
  logic [OP_W-2:0]   a_v;
  logic [LEAD_W-1:0] a_lead;
  logic [LEAD_W-1:0] lead_next;
  logic [OP_W-2:0]   sh;

  // leading one position
  always_comb begin
    lead_next = '0;
    for (int i = 0; i < OP_W - 1; i++) begin
      if (operand[i]) lead_next = LEAD_W'(i);
    end
  end

  // first stage: find the leading one
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
    if (en) begin
      a_zero <= (operand == '0) || operand[OP_W-1];
      a_v    <= operand[OP_W-2:0];
      a_lead <= lead_next;
    end
  end

  // bring the leading one to bit 23
  always_comb begin
    if (a_lead > LEAD_W'(M_W - 1)) begin
      sh = a_v >> (a_lead - LEAD_W'(M_W - 1));
    end else begin
      sh = a_v << (LEAD_W'(M_W - 1) - a_lead);
    end
  end

  // second stage: shifted mantissa and exponent
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_valid;
    end
    if (en) begin
      out_ctx.zero <= a_zero;
      out_ctx.m    <= sh[M_W-1:0];
      out_ctx.e    <= $signed({1'b0, a_lead}) - E_W'(signed'(M_W - 1));
      out_ctx.keep <= '0;
    end
  end

endmodule

>>> sv/fpsqrt_div_cell.sv
module fpsqrt_div_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  fpsqrt_pkg::div_beat_t   din,
  output fpsqrt_pkg::div_beat_t   dout
);
  import fpsqrt_pkg::*;

  logic [D_W:0]   trial;
  logic           ge;
  logic [D_W-1:0] rem_next;

  // one restoring step: shift in a bit, subtract if it fits
  always_comb begin
    trial    = {din.rem, din.lsb};
    ge       = trial >= {1'b0, din.dvsr};
    rem_next = ge ? D_W'(trial - {1'b0, din.dvsr}) : trial[D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.ctx  <= din.ctx;
      dout.dvsr <= din.dvsr;
      dout.rem  <= rem_next;
      dout.lsb  <= 1'b0;
      dout.quot <= {din.quot[Q_W-2:0], ge};
    end
  end

endmodule

>>> sv/fpsqrt_div.sv
module fpsqrt_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  fpsqrt_pkg::div_beat_t   din,
  output fpsqrt_pkg::div_beat_t   dout
);
  import fpsqrt_pkg::*;

  div_beat_t link [0:Q_W];

  assign link[0] = din;

  // one cell per quotient bit, msb first
  for (genvar i = 0; i < Q_W; i++) begin : g_cell
    fpsqrt_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (link[i]),
      .dout (link[i+1])
    );
  end

  assign dout = link[Q_W];

endmodule

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpsqrt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] operand = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ROOT_W-1:0] root;

  logic [OP_W-1:0] operands_pending[$];
  logic [ROOT_W-1:0] roots_due[$];
  int errors = 0;
  int cycles = 0;
  bit beat_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_mode_left = 0;

  fixed_point_square_root_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .operand(operand),
    .out_valid(out_valid), .out_stall(out_stall), .root(root)
  );

  // truncating fixed-point product and quotient
  function automatic logic [63:0] fx_product(logic [63:0] x, logic [63:0] y);
    logic [63:0] p;
    p = x * y;
    return p >> FRAC_BITS;
  endfunction

  function automatic logic [63:0] fx_quotient(logic [63:0] x, logic [63:0] y);
    if (y == 0) return 64'd0;
    return (x << FRAC_BITS) / y;
  endfunction

  // expected root of one operand
  function automatic logic [ROOT_W-1:0] root_predict(logic [OP_W-1:0] v);
    logic [31:0] m;
    int exp2;
    int half;
    logic [63:0] guess;
    logic [63:0] sum;
    if (v == 0 || v[OP_W-1]) return '0;
    m = v;
    exp2 = 0;
    // normalize into [2^23, 2^24)
    while ((m >> FRAC_BITS) != 0) begin
      m = m >> 1;
      exp2++;
    end
    while ((m >> (FRAC_BITS - 1)) == 0) begin
      m = m << 1;
      exp2--;
    end
    // linear first guess and two newton steps
    guess = 64'(COEF_A) + fx_product(64'(COEF_B), 64'(m));
    sum = guess + fx_quotient(64'(m), guess);
    guess = (sum >> 2) + fx_quotient(64'(m), sum);
    // odd exponent takes the 1/sqrt2 factor
    if (exp2 % 2 != 0) begin
      exp2++;
      guess = fx_product(64'(COEF_C), guess);
    end
    half = exp2 / 2;
    if (half >= 0) guess = guess << (half & 15);
    else guess = guess >> ((-half) & 31);
    return guess[ROOT_W-1:0];
  endfunction

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // input beat accepted: record expected root
  always @(posedge clk) begin
    beat_taken <= (!rst && in_valid && !in_stall);
    if (!rst && in_valid && !in_stall) begin
      roots_due.push_back(root_predict(operand));
    end
  end

  // driver: bursts with random gaps, payload held while stalled
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (operands_pending.size() > 0) begin
        operand <= operands_pending.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: phases of none, light, heavy and long holds
  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_mode_left <= $urandom_range(20, 200);
      out_stall <= 1'b0;
    end else begin
      stall_mode_left <= stall_mode_left - 1;
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 4) == 0);
        end
        2: begin
          out_stall <= ($urandom_range(0, 1) == 0);
        end
        default: begin
          out_stall <= ((stall_mode_left / 15) % 2 == 1);
        end
      endcase
    end
  end

  // monitor: compare each result beat with the oldest expected root
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (roots_due.size() == 0) begin
        $display("%0t: unexpected root beat, actual %0d", $time, root);
        errors++;
      end else begin
        logic [ROOT_W-1:0] want;
        want = roots_due.pop_front();
        if (root !== want) begin
          $display("%0t: root mismatch, expected %0d actual %0d", $time, want, root);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    logic [OP_W-1:0] v;
    int sel;
    // directed corners
    operands_pending.push_back(32'h0000_0000);
    operands_pending.push_back(32'hFFFF_FFFF);
    operands_pending.push_back(32'h8000_0000);
    operands_pending.push_back(32'h7FFF_FFFF);
    operands_pending.push_back(32'h0000_0001);
    operands_pending.push_back(32'h0000_0002);
    operands_pending.push_back(32'h0000_0003);
    operands_pending.push_back(32'h0080_0000);
    operands_pending.push_back(32'h00FF_FFFF);
    operands_pending.push_back(32'h0100_0000);
    operands_pending.push_back(32'h0100_0001);
    operands_pending.push_back(32'h0200_0000);
    operands_pending.push_back(32'h0400_0000);
    operands_pending.push_back(32'h4000_0000);
    operands_pending.push_back(32'h5555_5555);
    operands_pending.push_back(32'h2AAA_AAAA);
    operands_pending.push_back(32'h0000_8000);
    operands_pending.push_back(32'h0001_0000);
    operands_pending.push_back(32'hAAAA_AAAA);
    operands_pending.push_back(32'h8000_0001);
    // random: mostly positive at every magnitude, some negative and zero
    repeat (1500) begin
      sel = $urandom_range(0, 9);
      v = $urandom;
      if (sel < 6) v = {1'b0, v[30:0]} >> $urandom_range(0, 30);
      else if (sel < 8) v = {1'b0, v[30:0]};
      else if (sel == 9 && $urandom_range(0, 3) == 0) v = '0;
      operands_pending.push_back(v);
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (operands_pending.size() > 0 || in_valid) @(posedge clk);
    while (roots_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/fpsqrt_pkg.sv
sv/fpsqrt_norm.sv
sv/fpsqrt_div_cell.sv
sv/fpsqrt_div.sv
sv/fixed_point_square_root_core.sv
verif/tb.sv
